// ===== rtl/lrg_pkg.sv =====
// ----------------------------------------------------------------------------
// lrg_pkg
// Shared types and constants for the row-streaming life generation step.
// ----------------------------------------------------------------------------
package lrg_pkg;

    localparam int ROW_BITS      = 64;
    localparam int WIDTH_BITS    = 7;
    localparam int MAX_ROW_CELLS = 64;
    localparam int OUT_DEPTH     = 4;
    localparam int OUT_PTR_BITS  = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_BITS  = $clog2(OUT_DEPTH + 1);

    localparam logic [WIDTH_BITS-1:0] ACTIVE_WIDTH_RESET = 7'd10;

    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_ONE  = 2'd1;
    localparam logic [1:0] HELD_TWO  = 2'd2;

    localparam logic [3:0] COUNT_BIRTH   = 4'd3;
    localparam logic [3:0] COUNT_SURVIVE = 4'd2;

    // Neighbor bits one cell shows to the cells on either side
    typedef struct packed {
        logic up;
        logic mid;
        logic dn;
    } lrg_nbr_t;

    // Shared control driven to every cell
    typedef struct packed {
        logic load;
        logic flush;
    } lrg_cell_ctrl_t;

    // One result row with its end-of-grid marker
    typedef struct packed {
        logic                last;
        logic [ROW_BITS-1:0] row;
    } lrg_result_t;

endpackage

// ===== rtl/life_row_generation_step.sv =====
// ----------------------------------------------------------------------------
// life_row_generation_step
// B3/S23 life generation step over a grid streamed one row per transaction.
// ----------------------------------------------------------------------------
// Rows enter top first on the s_ channel, one per cycle with no gaps needed.
// A chain of ROW_CELLS column cells holds the two previous rows; each cell
// exchanges its row bits with both neighbors and counts its eight neighbors
// with a small adder in the same cycle the new row is taken. Each accepted
// row after the first of a grid gives the next generation of the row above
// it; a row with tlast also gives its own next generation and clears the
// store, so that row yields two results, or one when it is the only row of
// its grid. Results are written into a four-entry queue as the row is taken;
// the input stalls only when fewer than two queue entries are free.
// cfg_data sets the active width (reset 10; values above ROW_CELLS act as
// ROW_CELLS, zero leaves every column dead); columns at or beyond it read as
// dead and come out as zero.
module life_row_generation_step #(
    parameter int ROW_CELLS = lrg_pkg::MAX_ROW_CELLS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lrg_pkg::WIDTH_BITS-1:0]  cfg_data,    // active_width
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lrg_pkg::ROW_BITS-1:0]    s_tdata,     // row_cells
    input  logic                            s_tlast,     // last_row
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lrg_pkg::ROW_BITS-1:0]    m_tdata,     // next_row
    output logic                            m_tlast      // last_out
);
    import lrg_pkg::*;

    localparam logic [WIDTH_BITS-1:0] CELLS_W = WIDTH_BITS'(ROW_CELLS);

    logic [WIDTH_BITS-1:0] active_width_reg;
    logic [WIDTH_BITS-1:0] active_width_next;
    logic [1:0]            held_reg;
    logic [1:0]            held_next;
    logic [WIDTH_BITS-1:0] eff_width;
    logic                  accept;
    logic                  room_two;
    lrg_cell_ctrl_t        ctrl;
    lrg_nbr_t              nbr [ROW_CELLS+2];
    logic [ROW_CELLS-1:0]  col_en;
    logic [ROW_CELLS-1:0]  gen_mid;
    logic [ROW_CELLS-1:0]  gen_new;
    lrg_result_t           res_a;
    lrg_result_t           res_b;
    lrg_result_t           res_out;

    assign cfg_ready = 1'b1;
    assign s_tready  = room_two;
    assign accept    = s_tvalid & s_tready;
    assign eff_width = (active_width_reg > CELLS_W) ? CELLS_W : active_width_reg;
    assign ctrl      = '{load: accept, flush: s_tlast};

    assign nbr[0]           = '0;
    assign nbr[ROW_CELLS+1] = '0;

    for (genvar i = 0; i < ROW_CELLS; i++) begin : g_col
        assign col_en[i] = (WIDTH_BITS'(i) < eff_width);

        lrg_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .col_en    (col_en[i]),
            .row_bit   (s_tdata[i]),
            .nbr_left  (nbr[i]),
            .nbr_right (nbr[i+2]),
            .nbr_out   (nbr[i+1]),
            .next_mid  (gen_mid[i]),
            .next_new  (gen_new[i])
        );
    end

    assign res_a = '{last: 1'b0, row: ROW_BITS'(gen_mid)};
    assign res_b = '{last: 1'b1, row: ROW_BITS'(gen_new)};

    lrg_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_a    (accept & (held_reg != HELD_NONE)),
        .data_a    (res_a),
        .push_b    (accept & s_tlast),
        .data_b    (res_b),
        .room_two  (room_two),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res_out)
    );

    assign m_tdata = res_out.row;
    assign m_tlast = res_out.last;

    always_comb begin
        active_width_next = active_width_reg;
        if (cfg_valid & cfg_ready) begin
            active_width_next = cfg_data;
        end
        held_next = held_reg;
        if (accept) begin
            if (s_tlast) begin
                held_next = HELD_NONE;
            end else if (held_reg != HELD_NONE) begin
                held_next = HELD_TWO;
            end else begin
                held_next = HELD_ONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_width_reg <= ACTIVE_WIDTH_RESET;
            held_reg         <= HELD_NONE;
        end else begin
            active_width_reg <= active_width_next;
            held_reg         <= held_next;
        end
    end

    a_held_range: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg != 2'd3)
        else $error("held row count out of range");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept & s_tlast) |=> (held_reg == HELD_NONE))
        else $error("store not cleared after last row");

    a_row_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept & !s_tlast) |=> (held_reg != HELD_NONE))
        else $error("row not held after transaction");

endmodule

// ===== rtl/lrg_cell.sv =====
// ----------------------------------------------------------------------------
// lrg_cell
// One column of the grid: holds the upper and middle row bits of its column,
// shows them to its neighbors and forms the next-generation bits of the
// middle row and of the incoming row.
// ----------------------------------------------------------------------------
module lrg_cell (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  lrg_pkg::lrg_cell_ctrl_t ctrl,
    input  logic                   col_en,
    input  logic                   row_bit,
    input  lrg_pkg::lrg_nbr_t      nbr_left,
    input  lrg_pkg::lrg_nbr_t      nbr_right,
    output lrg_pkg::lrg_nbr_t      nbr_out,
    output logic                   next_mid,
    output logic                   next_new
);
    import lrg_pkg::*;

    logic       above_reg;
    logic       above_next;
    logic       middle_reg;
    logic       middle_next;
    logic       up;
    logic       mid;
    logic       dn;
    logic [3:0] count_mid;
    logic [3:0] count_new;

    assign up  = above_reg & col_en;
    assign mid = middle_reg & col_en;
    assign dn  = row_bit & col_en;

    assign nbr_out = '{up: up, mid: mid, dn: dn};

    always_comb begin
        count_mid = {3'b0, nbr_left.up}  + {3'b0, up}  + {3'b0, nbr_right.up}
                  + {3'b0, nbr_left.mid} + {3'b0, nbr_right.mid}
                  + {3'b0, nbr_left.dn}  + {3'b0, dn}  + {3'b0, nbr_right.dn};
        count_new = {3'b0, nbr_left.mid} + {3'b0, mid} + {3'b0, nbr_right.mid}
                  + {3'b0, nbr_left.dn}  + {3'b0, nbr_right.dn};
    end

    assign next_mid = col_en & ((count_mid == COUNT_BIRTH)
                                | (mid & (count_mid == COUNT_SURVIVE)));
    assign next_new = col_en & ((count_new == COUNT_BIRTH)
                                | (dn & (count_new == COUNT_SURVIVE)));

    always_comb begin
        above_next  = above_reg;
        middle_next = middle_reg;
        if (ctrl.load) begin
            if (ctrl.flush) begin
                above_next  = 1'b0;
                middle_next = 1'b0;
            end else begin
                above_next  = middle_reg;
                middle_next = dn;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            above_reg  <= 1'b0;
            middle_reg <= 1'b0;
        end else begin
            above_reg  <= above_next;
            middle_reg <= middle_next;
        end
    end

endmodule

// ===== rtl/lrg_out_fifo.sv =====
// ----------------------------------------------------------------------------
// lrg_out_fifo
// Small result queue: up to two rows in per cycle, one out when out_ready.
// ----------------------------------------------------------------------------
module lrg_out_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_a,
    input  lrg_pkg::lrg_result_t data_a,
    input  logic                 push_b,
    input  lrg_pkg::lrg_result_t data_b,
    output logic                 room_two,
    output logic                 out_valid,
    input  logic                 out_ready,
    output lrg_pkg::lrg_result_t out_data
);
    import lrg_pkg::*;

    lrg_result_t             mem [OUT_DEPTH];
    logic [OUT_PTR_BITS-1:0] wr_ptr_reg;
    logic [OUT_PTR_BITS-1:0] wr_ptr_next;
    logic [OUT_PTR_BITS-1:0] rd_ptr_reg;
    logic [OUT_PTR_BITS-1:0] rd_ptr_next;
    logic [OUT_CNT_BITS-1:0] count_reg;
    logic [OUT_CNT_BITS-1:0] count_next;
    logic [OUT_CNT_BITS-1:0] n_push;
    logic                    pop;
    lrg_result_t             first_data;

    assign n_push     = OUT_CNT_BITS'(push_a) + OUT_CNT_BITS'(push_b);
    assign first_data = push_a ? data_a : data_b;
    assign pop        = out_valid & out_ready;
    assign out_valid  = (count_reg != '0);
    assign out_data   = mem[rd_ptr_reg];
    assign room_two   = (count_reg <= OUT_CNT_BITS'(OUT_DEPTH - 2));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + OUT_PTR_BITS'(n_push);
        rd_ptr_next = rd_ptr_reg + OUT_PTR_BITS'(pop);
        count_next  = count_reg + n_push - OUT_CNT_BITS'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push_a | push_b) begin
            mem[wr_ptr_reg] <= first_data;
        end
        if (push_a & push_b) begin
            mem[wr_ptr_reg + OUT_PTR_BITS'(1)] <= data_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= OUT_CNT_BITS'(OUT_DEPTH))
        else $error("result queue count out of range");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_a | push_b) |-> (count_reg + n_push - OUT_CNT_BITS'(pop))
                              <= OUT_CNT_BITS'(OUT_DEPTH))
        else $error("result queue overflow");

endmodule

// ===== sim/life_row_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_row_checker
// Watches the row, result and width channels of the life generation step,
// tracks the two held rows and the active width on its own, works out every
// next-generation row that an accepted row causes and compares each result
// transaction, row and last flag, against the oldest one still waiting.
// ----------------------------------------------------------------------------
module life_row_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [lrg_pkg::WIDTH_BITS-1:0] cfg_data,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [lrg_pkg::ROW_BITS-1:0]   s_tdata,
    input  logic                           s_tlast,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [lrg_pkg::ROW_BITS-1:0]   m_tdata,
    input  logic                           m_tlast,
    output int                             fail_count,
    output int                             pending_count,
    output int                             checked_count
);
    import lrg_pkg::*;

    logic [WIDTH_BITS-1:0] width_reg = ACTIVE_WIDTH_RESET;
    logic [ROW_BITS-1:0]   upper_row = '0;
    logic [ROW_BITS-1:0]   waiting_row = '0;
    logic [1:0]            rows_held = HELD_NONE;
    lrg_result_t           next_gen_rows[$];

    initial begin
        fail_count    = 0;
        pending_count = 0;
        checked_count = 0;
    end

    function automatic int cols_in_use(input logic [WIDTH_BITS-1:0] w);
        return (w > MAX_ROW_CELLS) ? MAX_ROW_CELLS : int'(w);
    endfunction

    function automatic logic [ROW_BITS-1:0] cols_mask(input int n);
        if (n >= ROW_BITS) begin
            return '1;
        end
        return (64'd1 << n) - 64'd1;
    endfunction

    function automatic logic [ROW_BITS-1:0] evolve_row(input logic [ROW_BITS-1:0] up,
                                                       input logic [ROW_BITS-1:0] mid,
                                                       input logic [ROW_BITS-1:0] dn,
                                                       input int n);
        logic [ROW_BITS-1:0] res;
        int                  count;
        int                  c;
        res = '0;
        for (int i = 0; i < n; i++) begin
            count = 0;
            for (int d = -1; d <= 1; d++) begin
                c = i + d;
                if (c >= 0 && c < n) begin
                    count += int'(up[c]) + int'(dn[c]);
                    if (d != 0) begin
                        count += int'(mid[c]);
                    end
                end
            end
            res[i] = (count == COUNT_BIRTH) || (mid[i] && count == COUNT_SURVIVE);
        end
        return res;
    endfunction

    function automatic void take_row(input logic [ROW_BITS-1:0] cells, input logic is_last);
        int                  n;
        logic [ROW_BITS-1:0] keep;
        logic [ROW_BITS-1:0] row;
        logic [ROW_BITS-1:0] up;
        lrg_result_t         gen;
        n    = cols_in_use(width_reg);
        keep = cols_mask(n);
        row  = cells & keep;
        if (rows_held != HELD_NONE) begin
            up       = (rows_held == HELD_ONE) ? '0 : upper_row;
            gen.row  = evolve_row(up, waiting_row, row, n) & keep;
            gen.last = 1'b0;
            next_gen_rows.push_back(gen);
        end
        if (is_last) begin
            up       = (rows_held != HELD_NONE) ? waiting_row : '0;
            gen.row  = evolve_row(up, row, '0, n) & keep;
            gen.last = 1'b1;
            next_gen_rows.push_back(gen);
            upper_row   = '0;
            waiting_row = '0;
            rows_held   = HELD_NONE;
        end else begin
            upper_row   = (rows_held != HELD_NONE) ? waiting_row : '0;
            waiting_row = row;
            rows_held   = (rows_held != HELD_NONE) ? HELD_TWO : HELD_ONE;
        end
    endfunction

    // Sample at the falling edge: a handshake seen here completes at the next rising edge.
    always @(negedge aclk) begin : watch
        lrg_result_t want;
        if (!aresetn) begin
            width_reg   = ACTIVE_WIDTH_RESET;
            upper_row   = '0;
            waiting_row = '0;
            rows_held   = HELD_NONE;
            next_gen_rows.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                width_reg = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                take_row(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                if (next_gen_rows.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result: row %h last %b",
                             $time, m_tdata, m_tlast);
                end else begin
                    want = next_gen_rows.pop_front();
                    checked_count++;
                    if (m_tdata !== want.row) begin
                        fail_count++;
                        $display("%0t: next_row mismatch: expected %h, actual %h",
                                 $time, want.row, m_tdata);
                    end
                    if (m_tlast !== want.last) begin
                        fail_count++;
                        $display("%0t: last_out mismatch: expected %b, actual %b",
                                 $time, want.last, m_tlast);
                    end
                end
            end
        end
        pending_count = next_gen_rows.size();
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives grids of rows into the life generation step under several active
// widths, with random gaps and stalls on both channels and one long output
// hold-off, and bases the verdict on the checker's fail and pending counts.
// ----------------------------------------------------------------------------
module tb;
    import lrg_pkg::*;

    localparam int ITEM_TARGET   = 600;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_GAP       = 8;

    typedef enum int {FILL_HALF, FILL_SPARSE, FILL_DENSE} fill_kind_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [WIDTH_BITS-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [ROW_BITS-1:0]   s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [ROW_BITS-1:0]   m_tdata;
    logic                  m_tlast;

    int fail_count;
    int pending_count;
    int checked_count;

    bit sender_idle   = 1'b1;
    bit receiver_idle = 1'b1;
    int rx_hold       = 0;
    int rows_sent     = 0;
    int grids_sent    = 0;
    int width_writes  = 0;

    life_row_generation_step dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    life_row_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Result side: random stall per transaction, plus a long hold-off on request.
    initial begin : result_sink
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
                repeat (rx_hold) @(posedge aclk);
                rx_hold = 0;
            end
            stall = receiver_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(negedge aclk); while (!m_tvalid);
            @(posedge aclk);
        end
    end

    task automatic send_row(input logic [ROW_BITS-1:0] cells, input logic is_last);
        int gap;
        gap = sender_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cells;
        s_tlast  <= is_last;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        rows_sent++;
        if (is_last) begin
            grids_sent++;
        end
    endtask

    // Write only once every expected row is out and the block has settled.
    task automatic write_width(input logic [WIDTH_BITS-1:0] w);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        cfg_valid <= 1'b0;
        width_writes++;
    endtask

    function automatic logic [ROW_BITS-1:0] draw_row();
        fill_kind_t          kind;
        logic [ROW_BITS-1:0] a;
        logic [ROW_BITS-1:0] b;
        kind = fill_kind_t'($urandom_range(0, 2));
        a    = {$urandom, $urandom};
        b    = {$urandom, $urandom};
        case (kind)
            FILL_SPARSE: return a & b;
            FILL_DENSE:  return a | b;
            default:     return a;
        endcase
    endfunction

    function automatic logic [WIDTH_BITS-1:0] pick_width();
        logic [WIDTH_BITS-1:0] corner_widths[8] = '{7'd0, 7'd1, 7'd2, 7'd3,
                                                    7'd63, 7'd64, 7'd65, 7'd127};
        if ($urandom_range(0, 3) == 0) begin
            return corner_widths[$urandom_range(0, 7)];
        end
        return WIDTH_BITS'($urandom_range(1, 64));
    endfunction

    task automatic send_grid(input int height, input bit close);
        for (int r = 0; r < height; r++) begin
            send_row(draw_row(), close && (r == height - 1));
        end
    endtask

    initial begin : stimulus
        int directed_rows;
        int phase;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset width: single-row grid, blinker, stray bits past the width
        send_row('1, 1'b1);
        send_row(64'h0, 1'b0);
        send_row(64'h1C, 1'b0);
        send_row(64'h0, 1'b1);
        send_row('1, 1'b0);
        send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        send_row(64'h5555_5555_5555_5555, 1'b1);

        write_width(7'd0);
        send_row('1, 1'b0);
        send_row('1, 1'b1);

        write_width(7'd127);
        send_row('1, 1'b0);
        send_row(64'h8000_0000_0000_0001, 1'b0);
        send_row('1, 1'b1);

        write_width(7'd1);
        send_row(64'h1, 1'b0);
        send_row(64'h1, 1'b1);

        // Change the width while two rows are held
        write_width(7'd64);
        send_row(64'h8000_0000_0000_0003, 1'b0);
        send_row('1, 1'b0);
        write_width(7'd5);
        send_row('1, 1'b0);
        send_row(64'h1F, 1'b1);
        directed_rows = rows_sent;

        phase = 0;
        while (rows_sent - directed_rows < ITEM_TARGET) begin
            phase++;
            write_width(pick_width());
            sender_idle   = ($urandom_range(0, 3) != 0);
            receiver_idle = ($urandom_range(0, 3) != 0);
            if (phase == 3) begin
                sender_idle = 1'b0;
                rx_hold     = HOLD_CYCLES;
            end
            repeat ($urandom_range(2, 6)) send_grid($urandom_range(1, 8), 1'b1);
            if ($urandom_range(0, 3) == 0) begin
                send_grid($urandom_range(1, 3), 1'b0);
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES * 4) @(posedge aclk);

        $display("Summary: %0d rows in %0d closed grids, %0d width writes over %0d phases,",
                 rows_sent, grids_sent, width_writes, phase);
        $display("         %0d generation rows compared, %0d failures",
                 checked_count, fail_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/lrg_pkg.sv
rtl/lrg_cell.sv
rtl/lrg_out_fifo.sv
rtl/life_row_generation_step.sv
sim/life_row_checker.sv
sim/tb.sv
